FILE: rtl/irmt_pkg.sv
package irmt_pkg;

    localparam int MAX_MAPPINGS = 64;
    localparam int SLOT_W = $clog2(MAX_MAPPINGS);
    localparam int CNT_W = $clog2(MAX_MAPPINGS + 1);
    localparam int ENTRY_W = 192;

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] virt_addr;
        logic [63:0] phys_addr;
        logic [31:0] page_size;
        logic [31:0] page_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] byte_count;
        logic [63:0] phys_result;
    } t_rsp;

    typedef struct packed {
        logic [63:0] virt_base;
        logic [63:0] phys_base;
        logic [63:0] length;
    } t_entry;

endpackage

FILE: rtl/irmt_ram.sv
module irmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/iommu_range_map_table_unit.sv
// Each command takes one transaction on start and gives exactly one result, strobed by
// o_done for one cycle; the receiver cannot stall it. Map, unmap and translate sweep
// the 64 slots of the entry memory. For each slot, S_RD issues the read and S_SCAN
// examines the registered data. An unmap split with no free slot ends the sweep early.
// busy is high from the cycle after acceptance through the last working cycle and is low
// in the cycle that strobes the result, so the next command can be accepted at the end of
// that cycle. A translate passes through S_LEN for the length product, the sweep, and
// S_DONE to register the result. Map and unmap add S_CHK for the range check. A
// successful map adds S_MAPW for the write, and every split in an unmap adds S_SPLIT
// for the write of the tail entry. A range check failure or a map into a full table
// passes through S_RD and S_SCAN straight to S_DONE. A clear goes directly to S_DONE.
// The result is registered in S_DONE, the last busy state. The 64-bit length is formed
// by one 32x32 multiply.
module iommu_range_map_table_unit
    import irmt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_done,
    output t_rsp  o_rsp
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_LEN   = 8'b00000010,
        S_CHK   = 8'b00000100,
        S_RD    = 8'b00001000,
        S_SCAN  = 8'b00010000,
        S_MAPW  = 8'b00100000,
        S_SPLIT = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    t_req r_req;
    logic [63:0] r_len, r_end, r_total, r_phys;
    logic [1:0] r_status;
    logic [CNT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_rd_idx;
    logic [MAX_MAPPINGS-1:0] r_valid;
    logic r_found;
    logic r_hit;
    logic r_stop;
    logic r_done;
    t_rsp r_rsp;

    logic we;
    logic [SLOT_W-1:0] waddr, raddr;
    t_entry wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;

    irmt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_MAPPINGS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );
    assign rdata = t_entry'(rdata_raw);

    logic free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = MAX_MAPPINGS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
    end

    logic [63:0] ms, me, os, oe;
    logic ovl, slot_v;
    always_comb begin
        slot_v = r_valid[r_rd_idx];
        ms = rdata.virt_base;
        me = ms + rdata.length;
        ovl = slot_v && (r_req.virt_addr < me) && (ms < r_end);
        os = (r_req.virt_addr > ms) ? r_req.virt_addr : ms;
        oe = (r_end < me) ? r_end : me;
    end

    logic [63:0] toff;
    assign toff = r_req.virt_addr - ms;

    logic [63:0] prod;
    assign prod = 64'(r_req.page_size) * 64'(r_req.page_count);

    logic scan_last;
    assign scan_last = (r_rd_idx == SLOT_W'(MAX_MAPPINGS - 1));

    logic accept;
    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);

    t_entry r_split;
    logic [SLOT_W-1:0] r_split_idx;

    always_comb begin
        we = 1'b0;
        waddr = r_rd_idx;
        wdata = rdata;
        raddr = r_idx[SLOT_W-1:0];
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = (i_req.command == CMD_CLEAR) ? S_DONE : S_LEN;
            S_LEN:   n_state = (r_req.command == CMD_TRANSLATE) ? S_RD : S_CHK;
            S_CHK:   n_state = S_RD;
            S_RD:    n_state = S_SCAN;
            S_SCAN: begin
                if (r_stop) begin
                    n_state = S_DONE;
                end else if (r_req.command == CMD_UNMAP && ovl) begin
                    we = 1'b1;
                    if (os == ms && oe != me) begin
                        wdata.virt_base = oe;
                        wdata.phys_base = rdata.phys_base + (oe - ms);
                        wdata.length = me - oe;
                    end else if (os != ms) begin
                        wdata.length = os - ms;
                        if (oe != me && !free_any) we = 1'b0;
                    end else begin
                        we = 1'b0;
                    end
                    if (os != ms && oe != me) n_state = free_any ? S_SPLIT : S_DONE;
                    else if (scan_last) n_state = S_DONE;
                    else n_state = S_RD;
                end else if (scan_last) begin
                    n_state = (r_req.command == CMD_MAP && !r_found && !ovl) ? S_MAPW :
                        S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SPLIT: begin
                we = 1'b1;
                waddr = r_split_idx;
                wdata = r_split;
                n_state = (r_idx == CNT_W'(MAX_MAPPINGS)) ? S_DONE : S_RD;
            end
            S_MAPW: begin
                we = 1'b1;
                waddr = free_idx;
                wdata.virt_base = r_req.virt_addr;
                wdata.phys_base = r_req.phys_addr;
                wdata.length = r_len;
                n_state = S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req <= i_req;
                        r_status <= ST_OK;
                        r_total <= '0;
                        r_phys <= '0;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_hit <= 1'b0;
                        r_stop <= 1'b0;
                        if (i_req.command == CMD_CLEAR) r_valid <= '0;
                    end
                end
                S_LEN: begin
                    r_len <= prod;
                    r_end <= r_req.virt_addr + prod;
                end
                S_CHK: begin
                    if (r_req.page_size == '0 || r_req.page_count == '0 ||
                        r_end <= r_req.virt_addr) begin
                        r_status <= ST_INVALID;
                        r_stop <= 1'b1;
                    end else if (r_req.command == CMD_MAP && !free_any) begin
                        r_status <= ST_FULL;
                        r_stop <= 1'b1;
                    end
                end
                S_RD: begin
                    r_rd_idx <= r_idx[SLOT_W-1:0];
                    r_idx <= r_idx + 1'b1;
                end
                S_SCAN: begin
                    if (!r_stop) begin
                        case (r_req.command)
                            CMD_MAP: begin
                                if (ovl) begin
                                    r_found <= 1'b1;
                                    r_status <= ST_BUSY;
                                end
                            end
                            CMD_TRANSLATE: begin
                                if (!r_hit && slot_v && r_req.virt_addr >= ms &&
                                    toff < rdata.length) begin
                                    r_hit <= 1'b1;
                                    r_phys <= rdata.phys_base + toff;
                                end
                            end
                            CMD_UNMAP: begin
                                if (ovl) begin
                                    if (os == ms && oe == me) begin
                                        r_valid[r_rd_idx] <= 1'b0;
                                        r_total <= r_total + (oe - os);
                                    end else if (os != ms && oe != me) begin
                                        if (free_any) begin
                                            r_total <= r_total + (oe - os);
                                            r_valid[free_idx] <= 1'b1;
                                            r_split_idx <= free_idx;
                                            r_split.virt_base <= oe;
                                            r_split.phys_base <= rdata.phys_base + (oe - ms);
                                            r_split.length <= me - oe;
                                        end else begin
                                            r_status <= ST_FULL;
                                            r_total <= '0;
                                        end
                                    end else begin
                                        r_total <= r_total + (oe - os);
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAPW: r_valid[free_idx] <= 1'b1;
                S_DONE: begin
                    r_done <= 1'b1;
                    r_rsp.status <= r_status;
                    r_rsp.byte_count <= (r_req.command == CMD_UNMAP) ? r_total :
                        (r_req.command == CMD_MAP && r_status == ST_OK) ? r_len : '0;
                    r_rsp.phys_result <= (r_req.command == CMD_TRANSLATE) ? r_phys : '0;
                end
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp = r_rsp;
endmodule

FILE: rtl/irmt_checker.sv
module irmt_checker
    import irmt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after a transaction");
    a_done_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobed twice");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result without a transaction");
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_OK) |-> (o_rsp.byte_count == '0))
        else $error("failed command reported bytes");
endmodule

bind iommu_range_map_table_unit irmt_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_rsp(o_rsp)
);
